// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the bisection root finder. All checks run on clk and
// are held off while rst_n is low. They compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define CBRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when the antecedent holds, the consequent must hold in the same cycle
`define CBRF_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define CBRF_ASSERT(lbl, prop, msg)
`define CBRF_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/cbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbrf_pkg
// Shared types and constants of the bisection root finder: register indexes,
// reset values, and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package cbrf_pkg;

    // widths
    localparam int WORD_W  = 32;
    localparam int ACC_W   = 128;
    localparam int IDX_W   = 3;
    localparam int TOL_W   = 31;
    localparam int CAP_W   = 8;
    localparam int DEG_W   = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_COEF0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEGREE = 3'd4;
    localparam logic [IDX_W-1:0] REG_TOL    = 3'd5;
    localparam logic [IDX_W-1:0] REG_CAP    = 3'd6;

    // reset values
    localparam logic [DEG_W-1:0] DEGREE_RST = 2'd3;
    localparam logic [TOL_W-1:0] TOL_RST    = 31'd66;
    localparam logic [CAP_W-1:0] CAP_RST    = 8'd64;

    typedef logic [3:0][WORD_W-1:0] coef_arr_t;

    // controller to datapath
    typedef struct packed {
        logic       load;        // take a new item
        logic       eval_begin;  // seed accumulator with leading coefficient
        logic       mul_issue;   // multiply one accumulator limb
        logic [1:0] limb;        // limb being multiplied
        logic       acc_step;    // fold product and next coefficient
        logic [1:0] k;           // Horner step, 1..3
        logic       eval_end;    // polynomial sign is ready
        logic       eval_lo;     // evaluation was of the lower end
        logic       set_mid;     // form the midpoint
        logic       err_calc;    // absolute error
        logic       finish;      // register the result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tol_met;
        logic at_cap;
    } dp_stat_t;

endpackage

// ===== rtl/cubic_bisection_root_finder_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder_unit
// Bisection search for a root of a configured polynomial of degree zero to
// three in fixed point. An item is taken when start is high and busy is low;
// the block then evaluates f(lower_bound) once and runs passes until the
// midpoint lies within tolerance of reference_root or iteration_cap passes
// are made. Each Horner step runs the 128-bit accumulator through one
// 32x32 multiplier a limb per cycle. The result is on found_root,
// passes_used and limit_reached for the single cycle that done is high,
// and the receiver cannot stall it; the outputs hold until the next
// result. Configuration writes are taken at any time but only meant
// while busy is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cubic_bisection_root_finder_unit #(
    parameter int FRACTION_BITS = 16,
    parameter int MAX_DEGREE    = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_write,
    input  logic [cbrf_pkg::IDX_W-1:0]         cfg_index,
    input  logic [cbrf_pkg::WORD_W-1:0]        cfg_data,
    // command
    input  logic                               start,
    output logic                               busy,
    input  logic signed [cbrf_pkg::WORD_W-1:0] lower_bound,
    input  logic signed [cbrf_pkg::WORD_W-1:0] upper_bound,
    input  logic signed [cbrf_pkg::WORD_W-1:0] reference_root,
    // result
    output logic                               done,
    output logic signed [cbrf_pkg::WORD_W-1:0] found_root,
    output logic [cbrf_pkg::CAP_W-1:0]         passes_used,
    output logic                               limit_reached
);

    cbrf_pkg::coef_arr_t            coef_reg;
    logic [cbrf_pkg::DEG_W-1:0]     degree_reg;
    logic [cbrf_pkg::TOL_W-1:0]     tol_reg;
    logic [cbrf_pkg::CAP_W-1:0]     cap_reg;

    cbrf_pkg::dp_cmd_t              cmd;
    cbrf_pkg::dp_stat_t             stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg   <= '0;
            degree_reg <= cbrf_pkg::DEGREE_RST;
            tol_reg    <= cbrf_pkg::TOL_RST;
            cap_reg    <= cbrf_pkg::CAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cbrf_pkg::REG_COEF0:  coef_reg[0] <= cfg_data;
                cbrf_pkg::REG_COEF1:  coef_reg[1] <= cfg_data;
                cbrf_pkg::REG_COEF2:  coef_reg[2] <= cfg_data;
                cbrf_pkg::REG_COEF3:  coef_reg[3] <= cfg_data;
                cbrf_pkg::REG_DEGREE: degree_reg  <= cfg_data[cbrf_pkg::DEG_W-1:0];
                cbrf_pkg::REG_TOL:    tol_reg     <= cfg_data[cbrf_pkg::TOL_W-1:0];
                cbrf_pkg::REG_CAP:    cap_reg     <= cfg_data[cbrf_pkg::CAP_W-1:0];
                default:              ; // unmapped index, write dropped
            endcase
        end
    end

    cbrf_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .degree (degree_reg),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cbrf_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .coef           (coef_reg),
        .tolerance      (tol_reg),
        .iteration_cap  (cap_reg),
        .lower_bound    (lower_bound),
        .upper_bound    (upper_bound),
        .reference_root (reference_root),
        .found_root     (found_root),
        .passes_used    (passes_used),
        .limit_reached  (limit_reached)
    );

    // checks
    `CBRF_IMPLY(a_done_idle, done, !busy, "result shown while still busy")
    `CBRF_IMPLY(a_done_pass, done, passes_used != 8'd0, "result with no pass made")
    `CBRF_ASSERT(a_done_pulse, done |=> !done, "done held longer than one cycle")
    `CBRF_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted item did not start")

endmodule

// ===== rtl/cbrf_datapath.sv =====
// ----------------------------------------------------------------------------
// cbrf_datapath
// Interval, midpoint and error registers, plus the Horner evaluator: one
// 32x32 multiplier walks the 128-bit accumulator a limb per cycle.
// ----------------------------------------------------------------------------
module cbrf_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cbrf_pkg::dp_cmd_t                 cmd,
    output cbrf_pkg::dp_stat_t                stat,
    input  cbrf_pkg::coef_arr_t               coef,
    input  logic [cbrf_pkg::TOL_W-1:0]        tolerance,
    input  logic [cbrf_pkg::CAP_W-1:0]        iteration_cap,
    input  logic signed [cbrf_pkg::WORD_W-1:0] lower_bound,
    input  logic signed [cbrf_pkg::WORD_W-1:0] upper_bound,
    input  logic signed [cbrf_pkg::WORD_W-1:0] reference_root,
    output logic signed [cbrf_pkg::WORD_W-1:0] found_root,
    output logic [cbrf_pkg::CAP_W-1:0]        passes_used,
    output logic                              limit_reached
);

    localparam int W = cbrf_pkg::WORD_W;
    localparam int A = cbrf_pkg::ACC_W;

    logic [W-1:0]           lo_reg, hi_reg, ref_reg, mid_reg, x_reg;
    logic [W-1:0]           mag_reg;
    logic                   neg_reg;
    logic [A-1:0]           acc_reg, sum_reg;
    logic [2*W-1:0]         prod_reg;
    logic [1:0]             prod_idx_reg;
    logic                   prod_vld_reg;
    logic                   sign_lo_reg;
    logic [W:0]             diff_reg, err_reg;
    logic [cbrf_pkg::CAP_W-1:0] passes_reg;
    logic [W-1:0]           found_reg;
    logic [cbrf_pkg::CAP_W-1:0] passes_out_reg;
    logic                   limit_reg;

    logic [W:0]             mid_sum;
    logic [W-1:0]           mid_calc;
    logic [W-1:0]           limb_sel;
    logic [A-1:0]           term;
    logic [A-1:0]           prod_shift;
    logic [W+1:0]           found_wide;
    logic [W-1:0]           found_sat;
    logic [cbrf_pkg::CAP_W-1:0] cap_eff;
    logic                   sign_f;

    // midpoint: floor of the 33-bit sum over two
    always_comb
    begin
        mid_sum  = {lo_reg[W-1], lo_reg} + {hi_reg[W-1], hi_reg};
        mid_calc = mid_sum[W:1];
    end

    // limb of the accumulator going into the multiplier
    assign limb_sel = acc_reg[{cmd.limb, 5'b0} +: W];

    // coefficient term aligned to its power of the fraction scale
    always_comb
    begin
        case (cmd.k)
            2'd1:    term = A'($signed(coef[1])) << FRACTION_BITS;
            2'd2:    term = A'($signed(coef[2])) << (2 * FRACTION_BITS);
            default: term = A'($signed(coef[3])) << (3 * FRACTION_BITS);
        endcase
    end

    // partial product placed at its limb position
    always_comb
    begin
        case (prod_idx_reg)
            2'd0:    prod_shift = A'(prod_reg);
            2'd1:    prod_shift = A'(prod_reg) << W;
            2'd2:    prod_shift = A'(prod_reg) << (2 * W);
            default: prod_shift = A'(prod_reg) << (3 * W);
        endcase
    end

    // result: reference minus error, clipped to 32 bits signed
    always_comb
    begin
        found_wide = {{2{ref_reg[W-1]}}, ref_reg} - {1'b0, err_reg};
        if (found_wide[W+1:W-1] == 3'b000 || found_wide[W+1:W-1] == 3'b111)
            found_sat = found_wide[W-1:0];
        else if (found_wide[W+1])
            found_sat = {1'b1, {(W-1){1'b0}}};
        else
            found_sat = {1'b0, {(W-1){1'b1}}};
    end

    assign cap_eff      = (iteration_cap == '0) ? 8'd1 : iteration_cap;
    assign stat.tol_met = (err_reg <= {2'b00, tolerance});
    assign stat.at_cap  = (passes_reg >= cap_eff);
    assign sign_f       = ~acc_reg[A-1];

    // multiplier stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
        begin
            prod_reg     <= (2*W)'(limb_sel) * (2*W)'(mag_reg);
            prod_idx_reg <= cmd.limb;
        end
    end

    // Horner accumulator and product sum
    always_ff @(posedge clk)
    begin
        if (cmd.eval_begin)
        begin
            acc_reg  <= A'($signed(coef[0]));
            sum_reg  <= '0;
            neg_reg  <= x_reg[W-1];
            mag_reg  <= x_reg[W-1] ? (32'd0 - x_reg) : x_reg;
            diff_reg <= {ref_reg[W-1], ref_reg} - {mid_reg[W-1], mid_reg};
        end
        else if (cmd.acc_step)
        begin
            acc_reg <= neg_reg ? (term - sum_reg) : (term + sum_reg);
            sum_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            sum_reg <= sum_reg + prod_shift;
        end
    end

    // interval, pass count and error
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg     <= lower_bound;
            hi_reg     <= upper_bound;
            ref_reg    <= reference_root;
            x_reg      <= lower_bound;
            passes_reg <= '0;
        end
        if (cmd.set_mid)
        begin
            mid_reg <= mid_calc;
            x_reg   <= mid_calc;
        end
        if (cmd.eval_end)
        begin
            if (cmd.eval_lo)
                sign_lo_reg <= sign_f;
            else
            begin
                // f(lo) keeps its sign: lo only moves to a point of equal sign
                if (sign_f != sign_lo_reg)
                    hi_reg <= mid_reg;
                else
                    lo_reg <= mid_reg;
                passes_reg <= passes_reg + 8'd1;
            end
        end
        if (cmd.err_calc)
            err_reg <= diff_reg[W] ? (33'd0 - diff_reg) : diff_reg;
        if (cmd.finish)
        begin
            found_reg      <= found_sat;
            passes_out_reg <= passes_reg;
            limit_reg      <= ~stat.tol_met;
        end
    end

    assign found_root    = found_reg;
    assign passes_used   = passes_out_reg;
    assign limit_reached = limit_reg;

endmodule

// ===== rtl/cbrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbrf_ctrl
// Sequencer of the root finder: one evaluation of f(lower), then passes of
// midpoint, evaluation of f(mid), error and stop test.
// ----------------------------------------------------------------------------
module cbrf_ctrl #(
    parameter int MAX_DEGREE = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cbrf_pkg::DEG_W-1:0]  degree,
    input  cbrf_pkg::dp_stat_t          stat,
    output cbrf_pkg::dp_cmd_t           cmd,
    output logic                        busy,
    output logic                        done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BEGIN = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_END   = 4'd5;
    localparam logic [3:0] S_MID   = 4'd6;
    localparam logic [3:0] S_ERR   = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] limb_reg, limb_next;
    logic [1:0] k_reg, k_next;
    logic       eval_lo_reg, eval_lo_next;
    logic       done_reg, done_next;
    logic [1:0] n_deg;

    // effective degree
    assign n_deg = (degree > 2'(MAX_DEGREE)) ? 2'(MAX_DEGREE) : degree;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        limb_next    = limb_reg;
        k_next       = k_reg;
        eval_lo_next = eval_lo_reg;
        done_next    = 1'b0;
        cmd          = '0;
        cmd.limb     = limb_reg;
        cmd.k        = k_reg;
        cmd.eval_lo  = eval_lo_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    eval_lo_next = 1'b1;
                    state_next   = S_BEGIN;
                end
            end
            S_BEGIN:
            begin
                cmd.eval_begin = 1'b1;
                k_next         = 2'd1;
                limb_next      = 2'd0;
                state_next     = (n_deg == 2'd0) ? S_END : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_issue = 1'b1;
                limb_next     = limb_reg + 2'd1;
                if (limb_reg == 2'd3)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_step = 1'b1;
                if (k_reg == n_deg)
                    state_next = S_END;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_END:
            begin
                cmd.eval_end = 1'b1;
                state_next   = eval_lo_reg ? S_MID : S_ERR;
                eval_lo_next = 1'b0;
            end
            S_MID:
            begin
                cmd.set_mid = 1'b1;
                state_next  = S_BEGIN;
            end
            S_ERR:
            begin
                cmd.err_calc = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.tol_met || stat.at_cap)
                begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_MID;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            limb_reg    <= 2'd0;
            k_reg       <= 2'd1;
            eval_lo_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            limb_reg    <= limb_next;
            k_reg       <= k_next;
            eval_lo_reg <= eval_lo_next;
            done_reg    <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
